// File: rtl/dpdc_pkg.sv
package dpdc_pkg;

  localparam int LimitWidth = 16;
  localparam int DigitWidth = 4;
  localparam int SegWidth   = 8;

  typedef logic [LimitWidth-1:0] limit_t;
  typedef logic [DigitWidth-1:0] digit_t;
  typedef logic [SegWidth-1:0]   seg_t;

  localparam limit_t SettleReset  = limit_t'(16000);
  localparam digit_t DigitLast    = digit_t'(9);

  // One result beat.
  typedef struct packed {
    logic       clean_level;
    logic [1:0] update_count;
    digit_t     shown_digit;
    seg_t       segment_bits;
    logic       extra_segment;
  } result_t;

  // Contents of the input register handed to the update stage.
  typedef struct packed {
    logic valid;
    logic button_level;
  } stage_t;

  // Advance a decade digit, wrapping from nine back to zero.
  function automatic digit_t digit_inc(digit_t d);
    digit_inc = (d == DigitLast) ? '0 : digit_t'(d + digit_t'(1));
  endfunction

  // Seven-segment pattern on the eight-bit port for each digit.
  function automatic seg_t seg_port_d(digit_t d);
    unique case (d)
      4'd0:    seg_port_d = 8'b11011100;
      4'd1:    seg_port_d = 8'b11000000;
      4'd2:    seg_port_d = 8'b10110100;
      4'd3:    seg_port_d = 8'b11100100;
      4'd4:    seg_port_d = 8'b11101000;
      4'd5:    seg_port_d = 8'b01101100;
      4'd6:    seg_port_d = 8'b01111100;
      4'd7:    seg_port_d = 8'b11000000;
      4'd8:    seg_port_d = 8'b11111100;
      4'd9:    seg_port_d = 8'b11101100;
      default: seg_port_d = '0;
    endcase
  endfunction

  // The one segment that sits on the separate single-bit pin.
  function automatic logic seg_port_b0(digit_t d);
    unique case (d) inside
      4'd1, 4'd4: seg_port_b0 = 1'b0;
      default:    seg_port_b0 = 1'b1;
    endcase
  endfunction

endpackage

// File: rtl/dpdc_if.sv
interface dpdc_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface dpdc_out_if;
  import dpdc_pkg::*;
  logic       valid;
  logic       ready;
  logic       clean_level;
  logic [1:0] update_count;
  digit_t     shown_digit;
  seg_t       segment_bits;
  logic       extra_segment;

  modport source (output valid, output clean_level, output update_count,
                  output shown_digit, output segment_bits, output extra_segment,
                  input ready);
  modport sink   (input valid, input clean_level, input update_count,
                  input shown_digit, input segment_bits, input extra_segment,
                  output ready);
endinterface

interface dpdc_cfg_if;
  import dpdc_pkg::*;
  logic   valid;
  logic   ready;
  limit_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/dpdc_in_stage.sv
module dpdc_in_stage (
  input  logic            clk,
  input  logic            rst,
  dpdc_in_if.sink         button,
  input  logic            take,
  output dpdc_pkg::stage_t stage
);
  import dpdc_pkg::*;

  logic held_valid;
  logic held_level;

  // The register may refill in the same cycle as the update stage takes it.
  assign button.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (button.valid && button.ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (button.valid && button.ready) begin
      held_level <= button.button_level;
    end
  end

  assign stage.valid        = held_valid;
  assign stage.button_level = held_level;

endmodule

// File: rtl/dpdc_update.sv
module dpdc_update (
  input  logic             clk,
  input  logic             rst,
  input  dpdc_pkg::stage_t stage,
  output logic             take,
  dpdc_cfg_if.sink         cfg,
  dpdc_out_if.source       result
);
  import dpdc_pkg::*;

  limit_t settle_limit;
  limit_t rise_integrator, rise_integrator_next;
  limit_t fall_integrator, fall_integrator_next;
  logic   rise_armed, rise_armed_next;
  logic   fall_armed, fall_armed_next;
  logic   edge_seen, edge_seen_next;
  digit_t decade_count, decade_count_next;
  digit_t last_digit, last_digit_next;
  logic   level_reg, level_reg_next;
  logic   rise_fire, fall_fire;
  logic   pressed;
  logic   out_valid;

  assign cfg.ready = 1'b1;
  assign pressed   = stage.button_level;
  assign take      = stage.valid && (!out_valid || result.ready);

  always_comb begin
    rise_integrator_next = rise_integrator;
    fall_integrator_next = fall_integrator;
    rise_armed_next      = rise_armed;
    fall_armed_next      = fall_armed;
    edge_seen_next       = edge_seen;
    level_reg_next       = level_reg;
    rise_fire            = 1'b0;
    fall_fire            = 1'b0;

    // Rising integrator first.
    if (!pressed) begin
      if (rise_integrator != '0) begin
        rise_integrator_next = limit_t'(rise_integrator - limit_t'(1));
      end else begin
        rise_armed_next = 1'b1;
      end
    end else if (rise_integrator < settle_limit) begin
      rise_integrator_next = limit_t'(rise_integrator + limit_t'(1));
    end
    if (rise_integrator_next == '0) begin
      level_reg_next = 1'b0;
    end else if (rise_integrator_next == settle_limit && rise_armed_next) begin
      level_reg_next  = 1'b1;
      rise_fire       = 1'b1;
      rise_armed_next = 1'b0;
      edge_seen_next  = 1'b1;
    end

    // Falling integrator sees the edge flag as the rising stage left it.
    if (!pressed && edge_seen_next) begin
      if (fall_integrator < settle_limit) begin
        fall_integrator_next = limit_t'(fall_integrator + limit_t'(1));
      end
    end else if (fall_integrator != '0 && edge_seen_next) begin
      fall_integrator_next = limit_t'(fall_integrator - limit_t'(1));
    end else if (fall_integrator == '0) begin
      fall_armed_next = 1'b1;
    end
    if (fall_integrator_next == '0) begin
      level_reg_next = 1'b0;
    end else if (fall_integrator_next == settle_limit && fall_armed_next) begin
      level_reg_next  = 1'b1;
      fall_fire       = 1'b1;
      fall_armed_next = 1'b0;
    end

    // Digit bookkeeping: each firing shows the count and then advances it.
    last_digit_next   = last_digit;
    decade_count_next = decade_count;
    if (rise_fire && fall_fire) begin
      last_digit_next   = digit_inc(decade_count);
      decade_count_next = digit_inc(digit_inc(decade_count));
    end else if (rise_fire || fall_fire) begin
      last_digit_next   = decade_count;
      decade_count_next = digit_inc(decade_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_limit <= SettleReset;
    end else if (cfg.valid && cfg.ready) begin
      settle_limit <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_integrator <= '0;
      fall_integrator <= '0;
      rise_armed      <= 1'b0;
      fall_armed      <= 1'b0;
      edge_seen       <= 1'b0;
      decade_count    <= '0;
      last_digit      <= '0;
      level_reg       <= 1'b0;
    end else if (take) begin
      rise_integrator <= rise_integrator_next;
      fall_integrator <= fall_integrator_next;
      rise_armed      <= rise_armed_next;
      fall_armed      <= fall_armed_next;
      edge_seen       <= edge_seen_next;
      decade_count    <= decade_count_next;
      last_digit      <= last_digit_next;
      level_reg       <= level_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.clean_level   <= level_reg_next;
      result.update_count  <= {1'b0, rise_fire} + {1'b0, fall_fire};
      result.shown_digit   <= last_digit_next;
      result.segment_bits  <= seg_port_d(last_digit_next);
      result.extra_segment <= seg_port_b0(last_digit_next);
    end
  end

  assign result.valid = out_valid;

endmodule

// File: rtl/debounced_press_digit_counter_core.sv
// Debounced press digit counter. Each input beat carries one raw button
// sample; each accepted beat yields exactly one result beat giving the
// debounced level, how many display updates the sample caused (0, 1 or 2),
// the digit last sent to the display and its seven-segment pattern. Two
// saturating integrators filter the button against settle_limit, which resets
// to 16000; the user must write it through the cfg channel only while no beat
// is in flight, as the block itself does not enforce this. The block sustains
// one beat per clock while the output is not stalled: a beat is held in an
// input register and then passes through a single update stage into the
// result register. The integrator state is read and written in that update
// stage only, which is what lets successive samples follow one another without
// a gap. The input register refills in the same cycle it empties, so input is
// still taken while a finished result waits at the output; when the output is
// stalled, up to two beats are held before button.ready falls.
module debounced_press_digit_counter_core (
  input  logic       clk,
  input  logic       rst,
  dpdc_in_if.sink    button,
  dpdc_cfg_if.sink   cfg,
  dpdc_out_if.source result
);
  import dpdc_pkg::*;

  stage_t stage;
  logic   take;

  // Input register: one button sample waiting for the update stage.
  dpdc_in_stage u_in_stage (
    .clk    (clk),
    .rst    (rst),
    .button (button),
    .take   (take),
    .stage  (stage)
  );

  // Update stage: both integrators, the decade count and the result register.
  dpdc_update u_update (
    .clk    (clk),
    .rst    (rst),
    .stage  (stage),
    .take   (take),
    .cfg    (cfg),
    .result (result)
  );

endmodule
